[sv/seven_segment_frame_sequencer_assert.svh]
// Assertion macros for the seven-segment frame sequencer.
`ifndef SEVEN_SEGMENT_FRAME_SEQUENCER_ASSERT_SVH
`define SEVEN_SEGMENT_FRAME_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define SSFS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame sequencer check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SSFS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame sequencer check failed");

`else

`define SSFS_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SSFS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[sv/ssfs_pkg.sv]
// Shared types, codes, constants and the control store of the frame sequencer.
package ssfs_pkg;

  localparam int DIGIT_COUNT_DEFAULT = 4;

  localparam int STEP_W      = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int SRC_W       = 3;

  // Request modes.
  localparam logic [2:0] MODE_ALL     = 3'd0;
  localparam logic [2:0] MODE_ONE     = 3'd1;
  localparam logic [2:0] MODE_REFRESH = 3'd2;
  localparam logic [2:0] MODE_CLEAR   = 3'd3;
  localparam logic [2:0] MODE_SET     = 3'd4;
  localparam logic [2:0] MODE_REMOVE  = 3'd5;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_ADDR = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_POINT      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_AUTO_CMD   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FIXED_CMD  = 3'd4;

  // Fixed bytes of the driver protocol.
  localparam logic [7:0] CTRL_BASE = 8'h88;
  localparam logic [7:0] ADDR_BASE = 8'hC0;
  localparam logic [7:0] POINT_ADD = 8'h80;

  // Byte sources selected by a control word.
  localparam logic [SRC_W-1:0] SRC_AUTO  = 3'd0;
  localparam logic [SRC_W-1:0] SRC_ADDR  = 3'd1;
  localparam logic [SRC_W-1:0] SRC_DATA  = 3'd2;
  localparam logic [SRC_W-1:0] SRC_CTRL  = 3'd3;
  localparam logic [SRC_W-1:0] SRC_FIXED = 3'd4;
  localparam logic [SRC_W-1:0] SRC_INDEX = 3'd5;

  // Program entry points.
  localparam logic [STEP_W-1:0] ENTRY_ALL = 3'd0;
  localparam logic [STEP_W-1:0] ENTRY_ONE = 3'd4;

  typedef struct packed {
    logic [SRC_W-1:0]  src;
    logic              start;        // start condition before the byte
    logic              stop;         // stop condition after the byte
    logic              stop_at_last; // stop only after the last digit
    logic              loop_digits;  // repeat this step once per digit
    logic              last;         // final word of the request
    logic [STEP_W-1:0] next;
  } uop_t;

  // Control store. Both programs end in the shared display control step.
  function automatic uop_t uop_rom(input logic [STEP_W-1:0] step);
    uop_t u;
    u = '0;
    case (step)
      3'd0: begin
        u.src = SRC_AUTO;  u.start = 1'b1; u.stop = 1'b1; u.next = 3'd1;
      end
      3'd1: begin
        u.src = SRC_ADDR;  u.start = 1'b1; u.next = 3'd2;
      end
      3'd2: begin
        u.src = SRC_DATA;  u.stop_at_last = 1'b1; u.loop_digits = 1'b1; u.next = 3'd3;
      end
      3'd3: begin
        u.src = SRC_CTRL;  u.start = 1'b1; u.stop = 1'b1; u.last = 1'b1; u.next = ENTRY_ALL;
      end
      3'd4: begin
        u.src = SRC_FIXED; u.start = 1'b1; u.stop = 1'b1; u.next = 3'd5;
      end
      3'd5: begin
        u.src = SRC_INDEX; u.start = 1'b1; u.next = 3'd6;
      end
      3'd6: begin
        u.src = SRC_DATA;  u.stop = 1'b1; u.next = 3'd3;
      end
      default: begin
        u.src = SRC_CTRL;  u.start = 1'b1; u.stop = 1'b1; u.last = 1'b1; u.next = ENTRY_ALL;
      end
    endcase
    return u;
  endfunction

endpackage

[sv/seven_segment_frame_sequencer.sv]
// Seven-segment frame sequencer: digit store, microcoded byte sequencer, output register.

// The sequencer keeps one segment byte per digit and turns each request into the
// byte words that a two-wire LED driver expects, one word per clock on the output
// channel while it is not stalled. A whole-display request (write all, refresh,
// clear) produces DIGIT_COUNT + 3 words: the auto-increment command, the start
// address, one data byte per digit and the display control byte 0x88 plus
// brightness. A single-digit request (write one, set mask bits, remove mask bits)
// produces four words: the fixed-address command, the digit address, the data byte
// and the display control byte. Each word carries flags for the start and stop
// conditions around it and marks the last word of its request. Requests with an
// unused mode, and single-digit requests with a digit index at or beyond
// DIGIT_COUNT, are taken and dropped without any output. The next request is taken
// in the same cycle the last word enters the output register. The pace is set by
// the single output register, which the microcoded sequencer fills once per cycle
// unless the output is stalled. Configuration writes are always accepted and take
// effect the cycle after the write; they are meant to happen only while no request
// is in flight.

`include "seven_segment_frame_sequencer_assert.svh"

module seven_segment_frame_sequencer
  import ssfs_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // Request channel.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             mode,
  input  logic [1:0]             digit_index,
  input  logic [7:0]             seg0,
  input  logic [7:0]             seg1,
  input  logic [7:0]             seg2,
  input  logic [7:0]             seg3,
  // Frame word channel.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             wire_byte,
  output logic                   start_before,
  output logic                   stop_after,
  output logic                   last_of_run,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data
);

  // Width of the digit counter; it never holds DIGIT_COUNT itself.
  localparam int DIG_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [DIG_W-1:0] LAST_DIGIT = DIG_W'(DIGIT_COUNT - 1);

  // Configuration registers.
  logic [2:0] brightness_level;
  logic [7:0] start_address_command;
  logic       decimal_point_on;
  logic [7:0] auto_increment_command;
  logic [7:0] fixed_address_command;

  // Digit store and sequencer state.
  logic [7:0]        digits [DIGIT_COUNT];
  logic              running;
  logic [STEP_W-1:0] pc;
  logic [DIG_W-1:0]  dcnt;

  uop_t       uop;
  logic       step_go;
  logic       at_last_digit;
  logic       in_accept;
  logic       index_ok;
  logic       mode_all_kind;
  logic       mode_one_kind;
  logic [7:0] data_byte;
  logic [7:0] byte_sel;

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_level       <= 3'd7;
      start_address_command  <= ADDR_BASE;
      decimal_point_on       <= 1'b0;
      auto_increment_command <= 8'h40;
      fixed_address_command  <= 8'h44;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BRIGHTNESS: brightness_level       <= cfg_data[2:0];
        REG_START_ADDR: start_address_command  <= cfg_data;
        REG_POINT:      decimal_point_on       <= cfg_data[0];
        REG_AUTO_CMD:   auto_increment_command <= cfg_data;
        REG_FIXED_CMD:  fixed_address_command  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Current control word. While running, a step fires whenever the output register
  // is free or its word is being taken in this cycle.
  assign uop           = uop_rom(pc);
  assign step_go       = running && (!out_valid || !out_stall);
  assign at_last_digit = (dcnt == LAST_DIGIT);

  // A new request is taken while idle, or in the cycle the final word enters the output register.
  assign in_stall  = running && !(step_go && uop.last);
  assign in_accept = in_valid && !in_stall;

  assign index_ok      = (32'(digit_index) < DIGIT_COUNT);
  assign mode_all_kind = (mode == MODE_ALL) || (mode == MODE_REFRESH) || (mode == MODE_CLEAR);
  assign mode_one_kind = ((mode == MODE_ONE) || (mode == MODE_SET) || (mode == MODE_REMOVE))
                         && index_ok;

  // The point adds 0x80, wrapping at eight bits.
  assign data_byte = digits[dcnt] + (decimal_point_on ? POINT_ADD : 8'h00);

  always_comb begin
    case (uop.src)
      SRC_AUTO:  byte_sel = auto_increment_command;
      SRC_ADDR:  byte_sel = start_address_command;
      SRC_DATA:  byte_sel = data_byte;
      SRC_CTRL:  byte_sel = CTRL_BASE + {5'd0, brightness_level};
      SRC_FIXED: byte_sel = fixed_address_command;
      SRC_INDEX: byte_sel = ADDR_BASE | 8'(dcnt);
      default:   byte_sel = CTRL_BASE + {5'd0, brightness_level};
    endcase
  end

  // Digit store. Updates happen at request acceptance, before any byte is sent.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digits[i] <= 8'h00;
      end
    end else if (in_accept) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        case (mode)
          MODE_ALL: begin
            case (i)
              0:       digits[i] <= seg0;
              1:       digits[i] <= seg1;
              2:       digits[i] <= seg2;
              3:       digits[i] <= seg3;
              default: digits[i] <= 8'h00;
            endcase
          end
          MODE_CLEAR: digits[i] <= 8'h00;
          MODE_ONE: begin
            if (i == int'(digit_index)) begin
              digits[i] <= seg0;
            end
          end
          MODE_SET: begin
            if (i == int'(digit_index)) begin
              digits[i] <= digits[i] | seg0;
            end
          end
          MODE_REMOVE: begin
            if (i == int'(digit_index)) begin
              digits[i] <= digits[i] & ~seg0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Sequencer: step counter, digit counter and jumps taken from the control word.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      pc      <= ENTRY_ALL;
      dcnt    <= '0;
    end else begin
      if (step_go) begin
        if (uop.last) begin
          running <= 1'b0;
        end else if (uop.loop_digits && !at_last_digit) begin
          dcnt <= dcnt + 1'b1;
        end else begin
          pc <= uop.next;
        end
      end
      // A request taken in the final cycle of the previous one overrides it.
      if (in_accept) begin
        if (mode_all_kind) begin
          running <= 1'b1;
          pc      <= ENTRY_ALL;
          dcnt    <= '0;
        end else if (mode_one_kind) begin
          running <= 1'b1;
          pc      <= ENTRY_ONE;
          dcnt    <= DIG_W'(digit_index);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      wire_byte    <= byte_sel;
      start_before <= uop.start;
      stop_after   <= uop.stop || (uop.stop_at_last && at_last_digit);
      last_of_run  <= uop.last;
    end
  end

  // A whole-display request always starts the sequencer.
  `SSFS_ASSERT_NEXT(a_all_starts, clk, rst, in_accept && mode_all_kind, running && pc == ENTRY_ALL)

  // The last word of a request always closes with a stop condition.
  `SSFS_ASSERT_NOW(a_last_has_stop, clk, rst, out_valid && last_of_run, stop_after)

  // The digit counter never walks past the last stored digit.
  `SSFS_ASSERT_NOW(a_dcnt_range, clk, rst, running, dcnt <= LAST_DIGIT)

endmodule
